@@ design/sdc_pkg.sv @@
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types, widths and the microcode program of the smoothed derivative
// cascade.
// ----------------------------------------------------------------------------
package sdc_pkg;

  localparam int CY_W           = 20;
  localparam int VAL_W          = 40;
  localparam int ORDER_W        = 3;
  localparam int HALF_W         = 3;
  localparam int DIV_BITS       = 8;
  localparam int DEF_STAGES     = 4;
  localparam int DEF_MAX_WINDOW = 15;
  localparam logic [HALF_W-1:0] HALF_RESET = 3'd1;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_TAKE,
    OP_READ,
    OP_UPDATE,
    OP_DIV,
    OP_MEAN,
    OP_PUSH,
    OP_ZSTART,
    OP_ZERO,
    OP_CLEAR,
    OP_FINAL
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_NOT_FULL,
    C_DIV_MORE,
    C_NO_PREV,
    C_MORE_STAGES,
    C_NOT_EOS
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  localparam pc_t P_TAKE   = 4'd0;
  localparam pc_t P_READ   = 4'd1;
  localparam pc_t P_UPDATE = 4'd2;
  localparam pc_t P_DIV    = 4'd3;
  localparam pc_t P_MEAN   = 4'd4;
  localparam pc_t P_PUSH   = 4'd5;
  localparam pc_t P_ZSTART = 4'd6;
  localparam pc_t P_ZERO   = 4'd7;
  localparam pc_t P_CLEAR  = 4'd8;
  localparam pc_t P_FINAL  = 4'd9;

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      P_TAKE:   w = '{op: OP_TAKE,   cond: C_NO_INPUT,    target: P_TAKE};
      P_READ:   w = '{op: OP_READ,   cond: C_NEXT,        target: P_READ};
      P_UPDATE: w = '{op: OP_UPDATE, cond: C_NOT_FULL,    target: P_ZSTART};
      P_DIV:    w = '{op: OP_DIV,    cond: C_DIV_MORE,    target: P_DIV};
      P_MEAN:   w = '{op: OP_MEAN,   cond: C_NO_PREV,     target: P_ZSTART};
      P_PUSH:   w = '{op: OP_PUSH,   cond: C_MORE_STAGES, target: P_READ};
      P_ZSTART: w = '{op: OP_ZSTART, cond: C_NOT_EOS,     target: P_FINAL};
      P_ZERO:   w = '{op: OP_ZERO,   cond: C_MORE_STAGES, target: P_ZERO};
      P_CLEAR:  w = '{op: OP_CLEAR,  cond: C_NEXT,        target: P_CLEAR};
      P_FINAL:  w = '{op: OP_FINAL,  cond: C_ALWAYS,      target: P_TAKE};
      default:  w = '{op: OP_CLEAR,  cond: C_ALWAYS,      target: P_TAKE};
    endcase
    return w;
  endfunction

endpackage

@@ design/smoothed_derivative_cascade.sv @@
// ----------------------------------------------------------------------------
// smoothed_derivative_cascade
// Negated centroid position followed by a cascade of moving-average
// differentiators, run by a microcoded sequencer over a shared datapath.
// ----------------------------------------------------------------------------
// an item runs, for each stage it reaches, a memory read, sum update, the
// passes of the 8-bit-per-cycle divider, mean and push, then a zero pass
// over the stages and a clear on the final sample of a sequence; it waits
// while the result output is stalled
// one item at a time; each result is registered once the next one is found
// reset: synchronous; stage state cleared, half_width set to 1, store kept
module smoothed_derivative_cascade
  import sdc_pkg::*;
#(
  parameter int STAGES     = DEF_STAGES,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  input  logic [CY_W-1:0]         centroid_y,
  input  logic                    end_of_sequence,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [ORDER_W-1:0]      order,
  output logic signed [VAL_W-1:0] value,
  output logic                    last_of_run,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [HALF_W-1:0]       window_half
);

  localparam int WLEN_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W  = (WLEN_W > HALF_W + 1) ? WLEN_W : HALF_W + 1;
  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SIDX_W = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int DEPTH  = STAGES * MAX_WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = VAL_W + $clog2(MAX_WINDOW);
  localparam int ITER   = (SUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIVD_W = ITER * DIV_BITS;
  localparam int ITER_W = (ITER > 1) ? $clog2(ITER) : 1;
  localparam int REM_W  = WLEN_W;

  // sequencer
  pc_t                    pc, pc_next;
  ucode_t                 uw;
  logic                   taken, hold, needs_out;
  logic                   accept, out_free, cfg_we;

  // configuration
  logic [HALF_W-1:0]      half_width;
  logic [CMP_W-1:0]       wraw;
  logic [WLEN_W-1:0]      wlen;

  // per-stage state
  logic signed [SUM_W-1:0] sum       [STAGES];
  logic signed [VAL_W-1:0] prev      [STAGES];
  logic [WLEN_W-1:0]       fill      [STAGES];
  logic [PTR_W-1:0]        ptr       [STAGES];
  logic [STAGES-1:0]       have_prev;
  logic [STAGES-1:0]       emitted;

  // window store
  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_data;
  logic [ADDR_W-1:0]       addr;
  logic [ADDR_W-1:0]       base;
  logic [PTR_W-1:0]        evict_idx;
  logic [PTR_W-1:0]        ptr_inc;
  logic [WLEN_W+1:0]       pw;

  // datapath
  logic [SIDX_W-1:0]       s;
  logic                    last_stage;
  logic signed [VAL_W-1:0] x;
  logic signed [VAL_W-1:0] xin;
  logic                    eos;
  logic [ORDER_W-1:0]      pend_order;
  logic signed [VAL_W-1:0] pend_value;
  logic                    cur_full, full_next;
  logic signed [VAL_W-1:0] evict;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_new;
  logic [SUM_W-1:0]        mag;

  // divider
  logic [REM_W-1:0]        rem, dv_r;
  logic [DIVD_W-1:0]       quo, dv_q;
  logic [REM_W:0]          dv_t;
  logic                    neg;
  logic [ITER_W-1:0]       cnt;
  logic signed [VAL_W-1:0] mean;
  logic signed [VAL_W:0]   diff_wide;
  logic signed [VAL_W-1:0] diff_sat;

  assign accept       = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;
  assign cfg_we       = cfg_valid && cfg_ready;
  assign sample_stall = rst || (pc != P_TAKE);
  assign cfg_ready    = !rst && (pc == P_TAKE);
  assign uw           = ucode_rom(pc);

  // window length, clamped to the store depth
  assign wraw = CMP_W'({half_width, 1'b1});
  assign wlen = (wraw > CMP_W'(MAX_WINDOW)) ? WLEN_W'(MAX_WINDOW) : WLEN_W'(wraw);

  assign xin        = -$signed(VAL_W'({centroid_y, 8'h00}));
  assign last_stage = (s == SIDX_W'(STAGES - 1));
  assign cur_full   = (fill[s] >= wlen);
  assign full_next  = ((WLEN_W + 1)'(fill[s]) + (WLEN_W + 1)'(1)) >= (WLEN_W + 1)'(wlen);

  // circular store addressing
  assign pw        = (WLEN_W + 2)'(ptr[s]);
  assign evict_idx = (pw >= (WLEN_W + 2)'(wlen))
                     ? PTR_W'(pw - (WLEN_W + 2)'(wlen))
                     : PTR_W'(pw + (WLEN_W + 2)'(MAX_WINDOW) - (WLEN_W + 2)'(wlen));
  assign ptr_inc   = (ptr[s] == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr[s] + PTR_W'(1);
  assign base      = ADDR_W'(s) * ADDR_W'(MAX_WINDOW);
  assign addr      = (uw.op == OP_READ) ? base + ADDR_W'(evict_idx) : base + ADDR_W'(ptr[s]);

  // running sum and divider load
  assign evict    = cur_full ? rd_data : '0;
  assign sum_wide = (SUM_W + 1)'(sum[s]) + (SUM_W + 1)'(x) - (SUM_W + 1)'(evict);
  assign sum_new  = SUM_W'(sum_wide);
  assign mag      = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    dv_r = rem;
    dv_q = quo;
    dv_t = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      dv_t = {dv_r, dv_q[DIVD_W-1]};
      dv_q = {dv_q[DIVD_W-2:0], 1'b0};
      if (dv_t >= (REM_W + 1)'(wlen)) begin
        dv_r    = REM_W'(dv_t - (REM_W + 1)'(wlen));
        dv_q[0] = 1'b1;
      end else begin
        dv_r = dv_t[REM_W-1:0];
      end
    end
  end

  // mean and saturated difference
  assign mean      = neg ? -$signed(quo[VAL_W-1:0]) : $signed(quo[VAL_W-1:0]);
  assign diff_wide = (VAL_W + 1)'(mean) - (VAL_W + 1)'(prev[s]);
  always_comb begin
    if (diff_wide[VAL_W] != diff_wide[VAL_W-1]) begin
      diff_sat = diff_wide[VAL_W] ? {1'b1, {(VAL_W - 1){1'b0}}} : {1'b0, {(VAL_W - 1){1'b1}}};
    end else begin
      diff_sat = VAL_W'(diff_wide);
    end
  end

  // step sequencing
  always_comb begin
    case (uw.op)
      OP_PUSH:  needs_out = 1'b1;
      OP_FINAL: needs_out = 1'b1;
      OP_ZERO:  needs_out = !emitted[s];
      default:  needs_out = 1'b0;
    endcase
    hold = needs_out && !out_free;
    case (uw.cond)
      C_NEXT:        taken = 1'b0;
      C_ALWAYS:      taken = 1'b1;
      C_NO_INPUT:    taken = !accept;
      C_NOT_FULL:    taken = !full_next;
      C_DIV_MORE:    taken = (cnt != '0);
      C_NO_PREV:     taken = !have_prev[s];
      C_MORE_STAGES: taken = !last_stage;
      C_NOT_EOS:     taken = !eos;
      default:       taken = 1'b0;
    endcase
    if (hold) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  // control and stage state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= P_TAKE;
      half_width   <= HALF_RESET;
      result_valid <= 1'b0;
      s            <= '0;
      have_prev    <= '0;
      emitted      <= '0;
      for (int i = 0; i < STAGES; i++) begin
        sum[i]  <= '0;
        prev[i] <= '0;
        fill[i] <= '0;
        ptr[i]  <= '0;
      end
    end else begin
      pc <= pc_next;
      if (!hold && needs_out) begin
        result_valid <= 1'b1;
      end else if (out_free) begin
        result_valid <= 1'b0;
      end
      if (cfg_we || (uw.op == OP_CLEAR)) begin
        have_prev <= '0;
        emitted   <= '0;
        for (int i = 0; i < STAGES; i++) begin
          sum[i]  <= '0;
          prev[i] <= '0;
          fill[i] <= '0;
          ptr[i]  <= '0;
        end
      end
      if (cfg_we) begin
        half_width <= window_half;
      end
      if (!hold) begin
        case (uw.op)
          OP_TAKE: begin
            if (accept) begin
              s <= '0;
            end
          end
          OP_UPDATE: begin
            sum[s] <= sum_new;
            ptr[s] <= ptr_inc;
            if (!cur_full) begin
              fill[s] <= fill[s] + WLEN_W'(1);
            end
          end
          OP_MEAN: begin
            prev[s]      <= mean;
            have_prev[s] <= 1'b1;
            if (have_prev[s]) begin
              emitted[s] <= 1'b1;
            end
          end
          OP_PUSH: begin
            s <= s + SIDX_W'(1);
          end
          OP_ZSTART: begin
            s <= '0;
          end
          OP_ZERO: begin
            s <= s + SIDX_W'(1);
          end
          default: begin
          end
        endcase
      end
    end
  end

  // datapath and output payload
  always_ff @(posedge clk) begin
    if (!hold) begin
      case (uw.op)
        OP_TAKE: begin
          if (accept) begin
            x          <= xin;
            eos        <= end_of_sequence;
            pend_order <= '0;
            pend_value <= xin;
          end
        end
        OP_UPDATE: begin
          neg  <= sum_new[SUM_W-1];
          quo  <= DIVD_W'(mag);
          rem  <= '0;
          cnt  <= ITER_W'(ITER - 1);
        end
        OP_DIV: begin
          rem <= dv_r;
          quo <= dv_q;
          cnt <= cnt - ITER_W'(1);
        end
        OP_MEAN: begin
          x <= diff_sat;
        end
        OP_PUSH: begin
          order       <= pend_order;
          value       <= pend_value;
          last_of_run <= 1'b0;
          pend_order  <= ORDER_W'(s) + ORDER_W'(1);
          pend_value  <= x;
        end
        OP_ZERO: begin
          if (!emitted[s]) begin
            order       <= pend_order;
            value       <= pend_value;
            last_of_run <= 1'b0;
            pend_order  <= ORDER_W'(s) + ORDER_W'(1);
            pend_value  <= '0;
          end
        end
        OP_FINAL: begin
          order       <= pend_order;
          value       <= pend_value;
          last_of_run <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // window store: one write, one registered read
  always_ff @(posedge clk) begin
    if (uw.op == OP_UPDATE) begin
      mem[addr] <= x;
    end
    if (uw.op == OP_READ) begin
      rd_data <= mem[addr];
    end
  end

  a_take_starts_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> (pc == P_READ))
    else $error("accepted item did not start the stage program");

  a_rem_below_window: assert property (@(posedge clk) disable iff (rst)
    (pc == P_MEAN) |-> (rem < wlen))
    else $error("divider remainder not below window length");

  a_final_result: assert property (@(posedge clk) disable iff (rst)
    ((pc == P_FINAL) && out_free) |=> (result_valid && last_of_run && (pc == P_TAKE)))
    else $error("final result of an item not marked or sequencer not back at take");

  for (genvar g = 0; g < STAGES; g++) begin : g_stage_chk
    a_emitted_full: assert property (@(posedge clk) disable iff (rst)
      emitted[g] |-> (have_prev[g] && (fill[g] == wlen)))
      else $error("stage emitted without a full window and a previous mean");
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the smoothed derivative cascade with centroid tracks under several
// window settings and handshake idling patterns, predicts every position and
// difference result in a scoreboard, and checks each one as it leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import sdc_pkg::*;

typedef struct {
  logic [ORDER_W-1:0]      deriv_order;
  logic signed [VAL_W-1:0] deriv_value;
  logic                    run_end;
} deriv_result_t;

class derivative_board;
  logic [HALF_W-1:0] half;
  longint            taps[DEF_STAGES][DEF_MAX_WINDOW];
  longint            sums[DEF_STAGES];
  longint            last_mean[DEF_STAGES];
  int                filled[DEF_STAGES];
  bit                has_mean[DEF_STAGES];
  bit                emitted[DEF_STAGES];
  deriv_result_t     pending_results[$];
  int                mismatches;

  function new();
    half = HALF_RESET;
    mismatches = 0;
    clear_stages();
  endfunction

  function void clear_stages();
    for (int s = 0; s < DEF_STAGES; s++) begin
      for (int k = 0; k < DEF_MAX_WINDOW; k++) taps[s][k] = 0;
      sums[s] = 0;
      last_mean[s] = 0;
      filled[s] = 0;
      has_mean[s] = 0;
      emitted[s] = 0;
    end
  endfunction

  function void set_half(logic [HALF_W-1:0] h);
    half = h;
    clear_stages();
  endfunction

  function bit smooth_and_diff(int s, longint x, output longint y);
    int     w;
    longint mean;
    longint hi;
    longint diff;
    hi = (longint'(1) <<< (VAL_W - 1)) - 1;
    w = 2 * int'(half) + 1;
    if (w > DEF_MAX_WINDOW) w = DEF_MAX_WINDOW;
    y = 0;
    if (filled[s] >= w) begin
      sums[s] -= taps[s][w-1];
      filled[s] = w;
    end else begin
      filled[s]++;
    end
    for (int k = DEF_MAX_WINDOW - 1; k > 0; k--) taps[s][k] = taps[s][k-1];
    taps[s][0] = x;
    sums[s] += x;
    if (filled[s] < w) return 1'b0;
    mean = sums[s] / longint'(w);
    if (has_mean[s]) begin
      diff = mean - last_mean[s];
      if (diff > hi) diff = hi;
      if (diff < -hi - 1) diff = -hi - 1;
      y = diff;
      last_mean[s] = mean;
      emitted[s] = 1'b1;
      return 1'b1;
    end
    last_mean[s] = mean;
    has_mean[s] = 1'b1;
    return 1'b0;
  endfunction

  function void take_sample(logic [CY_W-1:0] cy, logic eos);
    int            n;
    bit            carry;
    longint        x;
    longint        y;
    int            ords[DEF_STAGES*2+1];
    longint        vals[DEF_STAGES*2+1];
    deriv_result_t r;
    n = 0;
    carry = 1'b1;
    x = -(longint'(cy) <<< 8);
    ords[n] = 0;
    vals[n] = x;
    n++;
    for (int s = 0; s < DEF_STAGES && carry; s++) begin
      carry = smooth_and_diff(s, x, y);
      if (carry) begin
        ords[n] = s + 1;
        vals[n] = y;
        n++;
        x = y;
      end
    end
    if (eos) begin
      for (int s = 0; s < DEF_STAGES; s++) begin
        if (!emitted[s]) begin
          ords[n] = s + 1;
          vals[n] = 0;
          n++;
        end
      end
      clear_stages();
    end
    for (int k = 0; k < n; k++) begin
      r.deriv_order = ORDER_W'(ords[k]);
      r.deriv_value = VAL_W'(vals[k]);
      r.run_end = (k == n - 1);
      pending_results = {pending_results, r};
    end
  endfunction

  function void match_result(logic [ORDER_W-1:0] o, logic signed [VAL_W-1:0] v, logic l);
    deriv_result_t e;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, order %0d value %0d last %0d", $time, o, v, l);
      mismatches++;
      return;
    end
    e = pending_results.pop_front();
    if (o !== e.deriv_order) begin
      $display("%0t: order expected %0d actual %0d", $time, e.deriv_order, o);
      mismatches++;
    end
    if (v !== e.deriv_value) begin
      $display("%0t: value (order %0d) expected %0d actual %0d",
               $time, e.deriv_order, e.deriv_value, v);
      mismatches++;
    end
    if (l !== e.run_end) begin
      $display("%0t: last_of_run (order %0d) expected %0d actual %0d",
               $time, e.deriv_order, e.run_end, l);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  localparam int LIMIT       = 400000;
  localparam int SETTLE_WAIT = 64;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    sample_valid = 1'b0;
  logic                    sample_stall;
  logic [CY_W-1:0]         centroid_y = '0;
  logic                    end_of_sequence = 1'b0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic [ORDER_W-1:0]      res_order;
  logic signed [VAL_W-1:0] res_value;
  logic                    res_last;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [HALF_W-1:0]       window_half = HALF_RESET;

  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              hold_cycles = 0;
  int              cycle_count = 0;
  derivative_board board = new();

  smoothed_derivative_cascade DUT (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .centroid_y      (centroid_y),
    .end_of_sequence (end_of_sequence),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .order           (res_order),
    .value           (res_value),
    .last_of_run     (res_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .window_half     (window_half)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: long hold-off when asked, random stalls otherwise
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      result_stall = 1'b1;
      hold_cycles--;
    end else begin
      result_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      board.match_result(res_order, res_value, res_last);
    end
  end

  task automatic send_sample(logic [CY_W-1:0] cy, logic eos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid = 1'b0;
      @(negedge clk);
    end
    sample_valid = 1'b1;
    centroid_y = cy;
    end_of_sequence = eos;
    do @(posedge clk); while (sample_stall);
    board.take_sample(cy, eos);
  endtask

  task automatic settle();
    @(negedge clk);
    sample_valid = 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_half(logic [HALF_W-1:0] h);
    @(negedge clk);
    cfg_valid = 1'b1;
    window_half = h;
    do @(posedge clk); while (!cfg_ready);
    board.set_half(h);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_tracks(int count, int min_len, int max_len);
    int              left;
    int              len;
    int              style;
    int              step;
    int              next;
    logic [CY_W-1:0] cy;
    left = count;
    while (left > 0) begin
      len = $urandom_range(min_len, max_len);
      if ($urandom_range(9) == 0) len = $urandom_range(1, 3);
      if (len > left) len = left;
      style = $urandom_range(2);
      cy = CY_W'($urandom);
      for (int i = 0; i < len; i++) begin
        case (style)
          0: begin
            cy = CY_W'($urandom);
          end
          1: begin
            step = int'($urandom_range(4095)) - 2048;
            next = int'(cy) + step;
            if (next < 0) next = 0;
            if (next > (1 << CY_W) - 1) next = (1 << CY_W) - 1;
            cy = CY_W'(next);
          end
          default: begin
            case ($urandom_range(2))
              0: cy = '0;
              1: cy = '1;
              default: cy = CY_W'($urandom);
            endcase
          end
        endcase
        send_sample(cy, i == len - 1);
      end
      left -= len;
    end
  endtask

  initial begin
    logic [CY_W-1:0] ramp[14];
    ramp = '{20'hFFFFF, 20'h00000, 20'hFFFFF, 20'h00000, 20'h80000, 20'h7FFFF, 20'h00001,
             20'hFFFFE, 20'h55555, 20'hAAAAA, 20'h00100, 20'h12345, 20'hFEDCB, 20'h00003};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset window, one-sample tracks, a track reaching every order, a short one
    send_sample('0, 1'b1);
    send_sample('1, 1'b1);
    for (int i = 0; i < 14; i++) send_sample(ramp[i], i == 13);
    for (int i = 0; i < 5; i++) send_sample(20'hFFFFF - 20'(i * 20'h3FFFF), i == 4);
    settle();

    write_half('0);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    run_tracks(30, 1, 12);
    settle();

    write_half('1);
    send_idle_pct = 57;
    recv_stall_pct = 0;
    run_tracks(70, 40, 70);
    settle();

    write_half(HALF_W'($urandom_range(1, 6)));
    send_idle_pct = 0;
    recv_stall_pct = 57;
    run_tracks(30, 1, 30);
    settle();

    // input side keeps offering while the output is held off
    write_half(HALF_W'(2));
    recv_stall_pct = 0;
    hold_cycles = 300;
    run_tracks(30, 1, 20);
    settle();

    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
